>>> rtl/oled_pkg.sv
// Shared types, constants and helper functions for the OLED display controller.
// No dependencies; imported by oled_display_controller, oled_ctrl and oled_render.
package oled_pkg;

    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 64;
    localparam int PAGE_COUNT   = (PANEL_HEIGHT + 7) / 8;
    localparam int STORE_SIZE   = PANEL_WIDTH * PAGE_COUNT;
    localparam int ADDR_W       = $clog2(STORE_SIZE);
    localparam int PAGE_W       = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

    // Item modes
    localparam logic [1:0] MODE_CMD  = 2'd0;
    localparam logic [1:0] MODE_DATA = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    // Command bytes
    localparam logic [7:0] CMD_CONTRAST = 8'h81;
    localparam logic [7:0] CMD_ALL_OFF  = 8'hA4;
    localparam logic [7:0] CMD_ALL_ON   = 8'hA5;
    localparam logic [7:0] CMD_NORMAL   = 8'hA6;
    localparam logic [7:0] CMD_INVERSE  = 8'hA7;
    localparam logic [7:0] CMD_DISP_OFF = 8'hAE;
    localparam logic [7:0] CMD_DISP_ON  = 8'hAF;

    localparam logic [7:0] CONTRAST_RST = 8'd255;

    // Display settings and frame store fill state, as seen by the read path
    typedef struct packed {
        logic [7:0]        contrast;
        logic              all_on;
        logic              inverse;
        logic              enabled;
        logic [ADDR_W-1:0] wr_addr;
        logic              wrapped;
    } t_disp_state;

    // 48 * c / 255, truncated; x/255 == (x + 1 + (x >> 8)) >> 8 for x < 65535
    function automatic logic [7:0] dim_level(input logic [7:0] c);
        logic [14:0] x;
        logic [14:0] s;
        x = {1'b0, c, 6'd0} - {3'd0, c, 4'd0};  // 64c - 16c
        s = x + 15'd1 + {8'd0, x[14:8]};
        return {1'b0, s[14:8]};
    endfunction

endpackage

>>> rtl/oled_display_controller.sv
// Top level of the monochrome page-mode OLED display controller.
// Depends on oled_pkg, oled_ram, oled_ctrl, oled_render.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-------------------------------------------
//  input   | in        | i_valid / o_stall | i_mode, i_byte_value, i_pixel_x, i_pixel_y
//  result  | out       | o_valid / i_stall | o_gray_level, o_pixel_lit
//
// One transaction per cycle is accepted while o_stall is low. A pixel read passes through the
// frame store's registered read and then the render register before its result appears.
// Commands and data bytes give no result and take effect at the accepting edge.
// Reset is synchronous, active low; the frame store needs no clearing pass, since a fill
// pointer marks which entries were written since reset, so items are taken right away.
// o_stall rises only when a read waits in stage 1 while the output holds a result and is stalled.
module oled_display_controller import oled_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_byte_value,
    input  logic [6:0] i_pixel_x,
    input  logic [5:0] i_pixel_y,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_gray_level,
    output logic       o_pixel_lit
);

    logic              acc;
    logic              acc_read;
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        rdata;
    t_disp_state       state;

    assign acc      = i_valid && !o_stall;
    assign acc_read = acc && (i_mode == MODE_READ);

    oled_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (acc),
        .i_mode       (i_mode),
        .i_byte_value (i_byte_value),
        .o_we         (we),
        .o_state      (state)
    );

    oled_ram #(
        .WIDTH (8),
        .DEPTH (STORE_SIZE)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (state.wr_addr),
        .i_wdata (i_byte_value),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    oled_render u_render (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc_read   (acc_read),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .i_state      (state),
        .o_re         (re),
        .o_raddr      (raddr),
        .i_rdata      (rdata),
        .i_stall      (i_stall),
        .o_busy       (o_stall),
        .o_valid      (o_valid),
        .o_gray_level (o_gray_level),
        .o_pixel_lit  (o_pixel_lit)
    );

endmodule

>>> rtl/oled_ram.sv
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module oled_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> rtl/oled_ctrl.sv
// Command decoder, display settings and frame store write pointer.
// Depends on oled_pkg.
module oled_ctrl import oled_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  logic [1:0]        i_mode,
    input  logic [7:0]        i_byte_value,
    output logic              o_we,
    output t_disp_state       o_state
);

    logic [7:0]        r_contrast;
    logic              r_all_on;
    logic              r_inverse;
    logic              r_enabled;
    logic              r_pending;
    logic [ADDR_W-1:0] r_wr_addr;
    logic              r_wrapped;

    logic              cmd_acc;
    logic              last_addr;

    assign cmd_acc   = i_acc && (i_mode == MODE_CMD);
    assign o_we      = i_acc && (i_mode == MODE_DATA);
    assign last_addr = (r_wr_addr == ADDR_W'(STORE_SIZE - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_contrast <= CONTRAST_RST;
            r_all_on   <= 1'b0;
            r_inverse  <= 1'b0;
            r_enabled  <= 1'b0;
            r_pending  <= 1'b0;
            r_wr_addr  <= '0;
            r_wrapped  <= 1'b0;
        end else begin
            if (cmd_acc) begin
                if (r_pending) begin
                    // argument byte of the contrast command
                    r_contrast <= i_byte_value;
                    r_pending  <= 1'b0;
                end else begin
                    case (i_byte_value)
                        CMD_CONTRAST: r_pending <= 1'b1;
                        CMD_ALL_OFF:  r_all_on  <= 1'b0;
                        CMD_ALL_ON:   r_all_on  <= 1'b1;
                        CMD_NORMAL:   r_inverse <= 1'b0;
                        CMD_INVERSE:  r_inverse <= 1'b1;
                        CMD_DISP_OFF: r_enabled <= 1'b0;
                        CMD_DISP_ON:  r_enabled <= 1'b1;
                        default:      ;
                    endcase
                end
            end
            // column/page pointer: store writes walk the addresses in order
            if (o_we) begin
                if (last_addr) begin
                    r_wr_addr <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_wr_addr <= r_wr_addr + ADDR_W'(1);
                end
            end
        end
    end

    assign o_state.contrast = r_contrast;
    assign o_state.all_on   = r_all_on;
    assign o_state.inverse  = r_inverse;
    assign o_state.enabled  = r_enabled;
    assign o_state.wr_addr  = r_wr_addr;
    assign o_state.wrapped  = r_wrapped;

endmodule

>>> rtl/oled_render.sv
// Pixel read path: address stage, then gray level render into the output register.
// Depends on oled_pkg.
module oled_render import oled_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc_read,
    input  logic [6:0]        i_pixel_x,
    input  logic [5:0]        i_pixel_y,
    input  t_disp_state       i_state,
    output logic              o_re,
    output logic [ADDR_W-1:0] o_raddr,
    input  logic [7:0]        i_rdata,
    input  logic              i_stall,
    output logic              o_busy,
    output logic              o_valid,
    output logic [7:0]        o_gray_level,
    output logic              o_pixel_lit
);

    logic              r_s1_valid;
    logic              r_s1_oob;
    logic              r_s1_written;
    logic [2:0]        r_s1_bitsel;
    logic [7:0]        r_s1_fg;
    logic [7:0]        r_s1_bg;
    logic              r_out_valid;

    logic              oob;
    logic [ADDR_W-1:0] rd_addr;
    logic              written;
    logic [7:0]        fg;
    logic [7:0]        bg;
    logic [7:0]        fg_sw;
    logic [7:0]        bg_sw;
    logic              advance;
    logic              bit_val;
    logic [7:0]        n_gray;
    logic              n_lit;

    assign oob     = ({25'd0, i_pixel_x} >= 32'(PANEL_WIDTH))
                  || ({26'd0, i_pixel_y} >= 32'(PANEL_HEIGHT));
    assign rd_addr = ADDR_W'(32'(i_pixel_y[5:3]) * 32'(PANEL_WIDTH) + 32'(i_pixel_x));
    // entry never written since reset reads as zero
    assign written = i_state.wrapped || (rd_addr < i_state.wr_addr);

    assign fg    = i_state.enabled ? i_state.contrast : 8'd0;
    assign bg    = (!i_state.enabled || i_state.all_on) ? fg : dim_level(i_state.contrast);
    assign fg_sw = i_state.inverse ? bg : fg;
    assign bg_sw = i_state.inverse ? fg : bg;

    assign o_re    = i_acc_read;
    assign o_raddr = rd_addr;

    assign advance = r_s1_valid && (!r_out_valid || !i_stall);
    // RAM data is only held while stage 1 waits, so block new items then
    assign o_busy  = r_s1_valid && r_out_valid && i_stall;

    assign bit_val = r_s1_written && i_rdata[r_s1_bitsel];
    assign n_lit   = !r_s1_oob && bit_val;
    assign n_gray  = r_s1_oob ? 8'd0 : (bit_val ? r_s1_fg : r_s1_bg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_acc_read) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc_read) begin
            r_s1_oob     <= oob;
            r_s1_written <= written;
            r_s1_bitsel  <= i_pixel_y[2:0];
            r_s1_fg      <= fg_sw;
            r_s1_bg      <= bg_sw;
        end
        if (advance) begin
            o_gray_level <= n_gray;
            o_pixel_lit  <= n_lit;
        end
    end

    assign o_valid = r_out_valid;

endmodule
